[rtl/core/pem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pem_pkg
// Shared constants, action codes and a reduction helper for the polynomial evaluator.
// ----------------------------------------------------------------------------
package pem_pkg;

    localparam int NumVars    = 64;
    localparam int MaxTerms   = 32;
    localparam int MaxFactors = 8;

    localparam int VarW  = 6;
    localparam int TermW = 5;
    localparam int FacW  = 3;
    localparam int CntW  = 4;
    localparam int SlotW = TermW + FacW;

    typedef logic [7:0] t_byte;

    localparam logic [2:0] ACT_STORE = 3'd0;
    localparam logic [2:0] ACT_COEF  = 3'd1;
    localparam logic [2:0] ACT_APPEND = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_EVAL  = 3'd4;

    // Reduce a value known to be below 2*m
    function automatic t_byte red1(input logic [8:0] x, input t_byte m);
        logic [8:0] d;
        d = x - {1'b0, m};
        red1 = (x >= {1'b0, m}) ? d[7:0] : x[7:0];
    endfunction

endpackage

[rtl/core/polynomial_eval_mod_p.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_eval_mod_p
// Sum-of-products polynomial evaluator modulo a configured modulus.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Word
// s_axis    in   i_s_axis_tvalid/tready  action,var_index,value,term_index,coef,power
// m_axis    out  o_m_axis_tvalid/tready  level,status
// cfg       in   i_cfg_valid/o_cfg_ready modulus
//
// Append, clear and undefined actions go from the load state straight to done;
// store and set coefficient first run the shift-subtract remainder.
// An evaluation walks the 32 terms, skipping absent ones, and takes each factor
// and each power step through one shared multiply and shift-subtract remainder.
// Reset runs a clearing pass over the state store; no word is taken until it
// ends. The output register holds a result while downstream stalls.
// ----------------------------------------------------------------------------
module polynomial_eval_mod_p (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // action, var_index, value, term_index, coef, power
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // level, status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data       // modulus
);
    import pem_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_TERM  = 4'd3;
    localparam logic [3:0] S_TRD   = 4'd4;
    localparam logic [3:0] S_FAC   = 4'd5;
    localparam logic [3:0] S_FRD   = 4'd6;
    localparam logic [3:0] S_VRD   = 4'd7;
    localparam logic [3:0] S_POW   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_RED   = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    // Where a finished remainder goes
    localparam logic [1:0] RET_STORE = 2'd0;
    localparam logic [1:0] RET_COEF  = 2'd1;
    localparam logic [1:0] RET_PROD  = 2'd2;
    localparam logic [1:0] RET_POW   = 2'd3;

    // Input field split
    logic [2:0] w_act;
    logic [5:0] w_var;
    t_byte      w_val, w_coef;
    logic [4:0] w_term;
    logic [3:0] w_pow;
    assign w_act  = i_s_axis_tdata[2:0];
    assign w_var  = i_s_axis_tdata[8:3];
    assign w_val  = i_s_axis_tdata[16:9];
    assign w_term = i_s_axis_tdata[21:17];
    assign w_coef = i_s_axis_tdata[29:22];
    assign w_pow  = i_s_axis_tdata[33:30];

    // Memories: state store and factor store
    t_byte            state_mem [NumVars];
    logic [9:0]       fac_mem   [MaxTerms*MaxFactors];
    t_byte            r_st_rd;
    logic [9:0]       r_fac_rd;

    // Term tables in flops (valid bits cleared at once)
    t_byte            r_coef [MaxTerms];
    logic [MaxTerms-1:0] r_pres;
    logic [CntW-1:0]  r_cnt  [MaxTerms];

    logic [3:0]  r_state;
    t_byte       r_mod;
    t_byte       m;
    logic [5:0]  r_ini;
    logic [2:0]  r_act;
    logic [5:0]  r_var;
    t_byte       r_val;
    logic [4:0]  r_term;
    t_byte       r_cf;
    logic [3:0]  r_pow;
    logic [3:0]  r_nf;
    logic [3:0]  r_fi;
    logic [3:0]  r_pi;
    t_byte       r_sum, r_prod, r_pw, r_base;
    logic [15:0] r_mul;
    logic [15:0] r_rem;
    logic [3:0]  r_rs;
    logic [1:0]  r_ret;
    logic        r_ovld;
    t_byte       r_olevel;
    logic        r_ostat;
    logic        w_ack;

    assign m = (r_mod < 8'd2) ? 8'd2 : r_mod;
    assign w_ack = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_ovld;
    assign o_cfg_ready = 1'b1;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata = {7'd0, r_ostat, r_olevel};

    // Remainder of a 16-bit product: shift-subtract, one bit a cycle
    logic [15:0] w_msh;
    logic [16:0] w_cmp;
    logic [15:0] w_red;
    assign w_msh = {8'd0, m} << r_rs;
    assign w_cmp = {1'b0, r_rem} - {1'b0, w_msh};
    assign w_red = w_cmp[16] ? r_rem : w_cmp[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mod   <= 8'd2;
            r_ini   <= '0;
            r_pres  <= '0;
            r_ovld  <= 1'b0;
            for (int i = 0; i < MaxTerms; i++) begin
                r_cnt[i]  <= '0;
                r_coef[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) r_mod <= i_cfg_data;
            if (r_ovld && i_m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                S_INIT: begin
                    state_mem[r_ini] <= '0;
                    r_ini <= r_ini + 6'd1;
                    if (r_ini == 6'(NumVars-1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (w_ack) begin
                        r_act <= w_act; r_var <= w_var; r_val <= w_val;
                        r_term <= w_term; r_cf <= w_coef; r_pow <= w_pow;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_olevel <= '0;
                    case (r_act)
                        ACT_STORE: begin
                            r_ostat <= 1'b0;
                            r_rem <= {8'd0, r_val}; r_rs <= 4'd8; r_ret <= RET_STORE;
                            r_state <= S_RED;
                        end
                        ACT_COEF: begin
                            r_ostat <= 1'b0;
                            r_rem <= {8'd0, r_cf}; r_rs <= 4'd8; r_ret <= RET_COEF;
                            r_pres[r_term] <= 1'b1;
                            r_state <= S_RED;
                        end
                        ACT_APPEND: begin
                            r_ostat <= (r_cnt[r_term] >= 4'(MaxFactors));
                            if (r_cnt[r_term] < 4'(MaxFactors)) begin
                                fac_mem[{r_term, r_cnt[r_term][FacW-1:0]}] <= {r_pow, r_var};
                                r_cnt[r_term] <= r_cnt[r_term] + 4'd1;
                            end
                            r_state <= S_DONE;
                        end
                        ACT_CLEAR: begin
                            r_ostat <= 1'b0;
                            r_pres <= '0;
                            for (int i = 0; i < MaxTerms; i++) begin
                                r_cnt[i]  <= '0;
                                r_coef[i] <= '0;
                            end
                            r_state <= S_DONE;
                        end
                        ACT_EVAL: begin
                            r_ostat <= 1'b0;
                            r_sum <= '0; r_term <= '0; r_state <= S_TERM;
                        end
                        default: begin
                            r_ostat <= 1'b0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // Start one term: skip it if absent, else reduce its coefficient
                S_TERM: begin
                    if (!r_pres[r_term]) begin
                        if (r_term == 5'(MaxTerms-1)) begin
                            r_olevel <= r_sum; r_state <= S_DONE;
                        end
                        r_term <= r_term + 5'd1;
                    end else begin
                        r_rem <= {8'd0, r_coef[r_term]}; r_rs <= 4'd8; r_ret <= RET_PROD;
                        r_nf <= r_cnt[r_term]; r_fi <= '0;
                        r_state <= S_RED;
                    end
                end
                // Next factor or term end
                S_FAC: begin
                    if (r_fi >= r_nf) begin
                        r_sum <= red1({1'b0, r_sum} + {1'b0, r_prod}, m);
                        r_term <= r_term + 5'd1;
                        if (r_term == 5'(MaxTerms-1)) begin
                            r_olevel <= red1({1'b0, r_sum} + {1'b0, r_prod}, m);
                            r_state <= S_DONE;
                        end else r_state <= S_TERM;
                    end else begin
                        r_fac_rd <= fac_mem[{r_term, r_fi[FacW-1:0]}];
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    r_st_rd <= state_mem[r_fac_rd[5:0]];
                    r_state <= S_VRD;
                end
                S_VRD: begin
                    r_rem <= {8'd0, r_st_rd}; r_rs <= 4'd8; r_ret <= RET_POW;
                    r_pi <= '0; r_pw <= '0;
                    r_state <= S_RED;
                end
                // One power step: prod *= base, or next factor once all steps are done
                S_POW: begin
                    if (r_pi >= r_fac_rd[9:6]) begin
                        r_fi <= r_fi + 4'd1; r_state <= S_FAC;
                    end else begin
                        r_mul <= {8'd0, r_prod} * {8'd0, r_base}; r_pi <= r_pi + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_rem <= r_mul; r_rs <= 4'd8; r_ret <= RET_POW; r_pw <= 8'd1;
                    r_state <= S_RED;
                end
                // Shift-subtract remainder, then return to caller
                S_RED: begin
                    r_rem <= w_red;
                    if (r_rs != 4'd0) begin
                        r_rs <= r_rs - 4'd1;
                    end else begin
                        case (r_ret)
                            RET_STORE: begin
                                state_mem[r_var] <= w_red[7:0]; r_state <= S_DONE;
                            end
                            RET_COEF: begin
                                r_coef[r_term] <= w_red[7:0]; r_state <= S_DONE;
                            end
                            RET_PROD: begin
                                r_prod <= w_red[7:0]; r_state <= S_FAC;
                            end
                            default: begin
                                if (r_pw == 8'd0) r_base <= w_red[7:0];
                                else r_prod <= w_red[7:0];
                                r_state <= S_POW;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    r_ovld <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> !o_s_axis_tready) else $error("input taken while result pending");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> r_ovld) else $error("result not raised");
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_olevel < m)) else $error("level not reduced");
`endif

endmodule

[sim/polynomial_eval_mod_p_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_eval_mod_p_tb
// Drives load, append, clear and evaluate words into the polynomial evaluator
// under several moduli and checks each result word against a local predictor.
// ----------------------------------------------------------------------------
module polynomial_eval_mod_p_tb;
    import pem_pkg::*;

    typedef struct packed {
        logic [3:0] power;
        logic [7:0] coef;
        logic [4:0] term_index;
        logic [7:0] value;
        logic [5:0] var_index;
        logic [2:0] action;
    } t_cmd;

    typedef struct packed {
        logic       status;
        logic [7:0] level;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    polynomial_eval_mod_p u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor copy of the evaluator state
    int unsigned cur_modulus;
    int unsigned var_vals [NumVars];
    int unsigned coefs [MaxTerms];
    bit          present [MaxTerms];
    int unsigned n_factors [MaxTerms];
    int unsigned fac_var [MaxTerms][MaxFactors];
    int unsigned fac_pow [MaxTerms][MaxFactors];

    t_cmd pending_cmds [$];
    t_res expected_results [$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    // append one word to the pending queue
    task automatic add_cmd(input t_cmd c);
        pending_cmds = {pending_cmds, c};
    endtask

    function automatic int unsigned poly_value();
        int unsigned m;
        int unsigned sum;
        int unsigned prod;
        int unsigned base;
        m = cur_modulus < 2 ? 2 : cur_modulus;
        sum = 0;
        for (int t = 0; t < MaxTerms; t++) begin
            if (!present[t]) continue;
            prod = coefs[t] % m;
            for (int f = 0; f < n_factors[t]; f++) begin
                base = var_vals[fac_var[t][f]] % m;
                for (int p = 0; p < fac_pow[t][f]; p++) prod = (prod * base) % m;
            end
            sum = (sum + prod) % m;
        end
        return sum;
    endfunction

    // apply one accepted word to the predictor and queue its result
    task automatic predict_word(input t_cmd c);
        int unsigned m;
        t_res r;
        m = cur_modulus < 2 ? 2 : cur_modulus;
        r = '0;
        case (c.action)
            ACT_STORE: var_vals[c.var_index] = c.value % m;
            ACT_COEF: begin
                coefs[c.term_index] = c.coef % m;
                present[c.term_index] = 1'b1;
            end
            ACT_APPEND: begin
                if (n_factors[c.term_index] >= MaxFactors) begin
                    r.status = 1'b1;
                end else begin
                    fac_var[c.term_index][n_factors[c.term_index]] = c.var_index;
                    fac_pow[c.term_index][n_factors[c.term_index]] = c.power;
                    n_factors[c.term_index]++;
                end
            end
            ACT_CLEAR: begin
                for (int t = 0; t < MaxTerms; t++) begin
                    coefs[t] = 0;
                    present[t] = 1'b0;
                    n_factors[t] = 0;
                end
            end
            ACT_EVAL: r.level = 8'(poly_value());
            default: ;
        endcase
        expected_results = {expected_results, r};
    endtask

    // driver: present words from the pending queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tdata <= {6'd0, pending_cmds[0]};
                    i_s_axis_tvalid <= 1'b1;
                    predict_word(pending_cmds.pop_front());
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_res got;
        t_res exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[8:0];
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word, actual level %0d status %0d",
                         $time, got.level, got.status);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.level !== exp_r.level)
                    $display("%0t: level mismatch, expected %0d actual %0d",
                             $time, exp_r.level, got.level);
                if (got.status !== exp_r.status)
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, exp_r.status, got.status);
                if (got.level !== exp_r.level || got.status !== exp_r.status) errors++;
                if (o_m_axis_tdata[15:9] !== 7'd0) begin
                    $display("%0t: pad bits, expected 0 actual %0h",
                             $time, o_m_axis_tdata[15:9]);
                    errors++;
                end
            end
        end
    end

    function automatic t_cmd mk(input logic [2:0] a, input int v, input int val,
                                input int t, input int cf, input int p);
        t_cmd c;
        c.action = a; c.var_index = v[5:0]; c.value = val[7:0];
        c.term_index = t[4:0]; c.coef = cf[7:0]; c.power = p[3:0];
        return c;
    endfunction

    // random word, mostly building polynomials and evaluating them
    function automatic t_cmd rand_cmd();
        int sel;
        sel = $urandom_range(99);
        if (sel < 25) return mk(ACT_STORE, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (sel < 40) return mk(ACT_COEF, $urandom, $urandom,
                                $urandom_range(7), $urandom, $urandom);
        if (sel < 70) return mk(ACT_APPEND, $urandom, $urandom,
                                $urandom_range(7), $urandom, $urandom_range(3));
        if (sel < 73) return mk(ACT_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (sel < 75) return mk(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (sel < 97) return mk(ACT_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom);
        return mk(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic write_modulus(input logic [7:0] m);
        @(posedge i_clk);
        i_cfg_data <= m;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_modulus = m;
    endtask

    // wait for all results, then let the block settle
    task automatic drain();
        while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++) add_cmd(rand_cmd());
        drain();
    endtask

    initial begin
        logic [7:0] mods [6];
        cur_modulus = 2;
        for (int i = 0; i < NumVars; i++) var_vals[i] = 0;
        for (int t = 0; t < MaxTerms; t++) begin
            coefs[t] = 0; present[t] = 0; n_factors[t] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: evaluate at reset modulus, then at 255
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        add_cmd(mk(ACT_STORE, 0, 255, 0, 0, 0));
        drain();
        write_modulus(8'd255);
        add_cmd(mk(ACT_STORE, 63, 255, 31, 255, 15));
        add_cmd(mk(ACT_STORE, 5, 0, 0, 0, 0));
        add_cmd(mk(ACT_STORE, 1, 254, 0, 0, 0));
        add_cmd(mk(ACT_APPEND, 63, 0, 31, 0, 15));  // no coef yet
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        add_cmd(mk(ACT_COEF, 0, 0, 31, 254, 0));
        add_cmd(mk(ACT_APPEND, 5, 0, 31, 0, 0));     // zero to power zero
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        for (int f = 0; f < 7; f++) add_cmd(mk(ACT_APPEND, 1, 0, 0, 0, f));
        add_cmd(mk(ACT_APPEND, 1, 0, 0, 0, 15));    // eighth factor fills the list
        add_cmd(mk(ACT_COEF, 0, 0, 0, 255, 0));
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        add_cmd(mk(3'd7, 63, 255, 31, 255, 15));
        add_cmd(mk(3'd5, 0, 0, 0, 0, 0));
        drain();
        // modulus below two, then reduction of stored values by a new modulus
        write_modulus(8'd1);
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        drain();
        write_modulus(8'd0);
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        add_cmd(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
        add_cmd(mk(ACT_EVAL, 0, 0, 0, 0, 0));
        drain();

        mods = '{8'd7, 8'd255, 8'd2, 8'd128, 8'd13, 8'd251};
        for (int ph = 0; ph < 6; ph++) begin
            write_modulus(mods[ph]);
            if (ph < 2) begin
                send_idle_pct = 9; recv_idle_pct = 50;
            end else if (ph < 4) begin
                send_idle_pct = 50; recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            run_random(260);
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2s;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
